/* hw/rtl/ssc_pkg.sv */
// Shared types and constants for the subset sum counter.
// Holds the table geometry, the count modulus, the controller states and the
// command and status bundles that join the controller to the datapath.
`timescale 1ns / 1ps
`default_nettype none

package ssc_pkg;

  localparam int MAX_SUM   = 1023;
  localparam int TBL_DEPTH = MAX_SUM + 1;
  localparam int ADDR_W    = $clog2(TBL_DEPTH);

  localparam int VALUE_W  = 16;
  localparam int TARGET_W = 10;
  localparam int COUNT_W  = 30;

  localparam logic [COUNT_W-1:0] COUNT_MOD = COUNT_W'(1000000007);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_DRAIN,
    ST_FETCH,
    ST_RESULT
  } ssc_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;  // latch the accepted item, point the address at the target
    logic upd;        // read entries s and s - v, schedule the write of s
    logic dec;        // step the address down by one
    logic seek_tgt;   // point the address at the target
    logic fetch;      // read the entry at the address
    logic out_load;   // move the fetched count into the output register
    logic clr_rst;    // point the address at entry zero
    logic clr_wr;     // write the reset value at the address and step up
  } ssc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic item_fits;  // incoming element is not above the target
    logic item_last;  // incoming element closes the set
    logic at_low;     // address has reached the element value
    logic last;       // latched item closes the set
    logic clr_done;   // address is at the top entry of the table
    logic out_free;   // output register can take a new result
  } ssc_status_t;

endpackage

`default_nettype wire

/* hw/rtl/ssc_datapath.sv */
// Datapath of the subset sum counter: configuration register, address counter,
// the table memory with two read ports, the modular adder and the output register.
// Depends on ssc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssc_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic [ssc_pkg::TARGET_W-1:0] cfg_wr_data,
  input  wire logic [ssc_pkg::VALUE_W-1:0]  in_element_value,
  input  wire logic                         in_last_element,
  input  wire logic                         out_ready,
  output logic                              out_valid,
  output logic [ssc_pkg::COUNT_W-1:0]       out_subset_count,
  input  wire ssc_pkg::ssc_cmd_t            cmd_i,
  output ssc_pkg::ssc_status_t              sts_o
);
  import ssc_pkg::*;

  logic [TARGET_W-1:0] target_r;
  logic [ADDR_W-1:0]   eff_target;
  logic [ADDR_W-1:0]   t_r;
  logic [ADDR_W-1:0]   v_r;
  logic                last_r;
  logic [ADDR_W-1:0]   s_r;
  logic [ADDR_W-1:0]   s_nxt;
  logic [ADDR_W-1:0]   addr_lo;

  logic [COUNT_W-1:0]  mem [TBL_DEPTH];
  logic [COUNT_W-1:0]  rd_hi_r;
  logic [COUNT_W-1:0]  rd_lo_r;
  logic                wr_pend_r;
  logic [ADDR_W-1:0]   wr_addr_r;

  logic [COUNT_W:0]    sum_raw;
  logic [COUNT_W-1:0]  sum_mod;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [COUNT_W-1:0]  wr_data;

  logic                out_valid_r;
  logic [COUNT_W-1:0]  out_count_r;

  // A target beyond the table is clamped to its top entry.
  always_comb begin
    if (32'(target_r) > MAX_SUM) begin
      eff_target = ADDR_W'(MAX_SUM);
    end else begin
      eff_target = ADDR_W'(target_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (cfg_wr_en) begin
      target_r <= cfg_wr_data;
    end
  end

  // Item registers.
  always_ff @(posedge clk) begin
    if (cmd_i.load_item) begin
      t_r    <= eff_target;
      v_r    <= ADDR_W'(in_element_value);
      last_r <= in_last_element;
    end
  end

  // Address counter.
  always_comb begin
    s_nxt = s_r;
    if (cmd_i.load_item) begin
      s_nxt = eff_target;
    end else if (cmd_i.seek_tgt) begin
      s_nxt = t_r;
    end else if (cmd_i.clr_rst) begin
      s_nxt = '0;
    end else if (cmd_i.dec) begin
      s_nxt = s_r - 1'b1;
    end else if (cmd_i.clr_wr) begin
      s_nxt = s_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= '0;
    end else begin
      s_r <= s_nxt;
    end
  end

  assign addr_lo = s_r - v_r;

  // Modular sum of the two read entries; both are below the modulus.
  assign sum_raw = {1'b0, rd_hi_r} + {1'b0, rd_lo_r};
  always_comb begin
    if (sum_raw >= {1'b0, COUNT_MOD}) begin
      sum_mod = COUNT_W'(sum_raw - {1'b0, COUNT_MOD});
    end else begin
      sum_mod = COUNT_W'(sum_raw);
    end
  end

  // One write port shared by the update write-back and the clearing sweep.
  always_comb begin
    wr_en   = wr_pend_r | cmd_i.clr_wr;
    wr_addr = wr_pend_r ? wr_addr_r : s_r;
    if (wr_pend_r) begin
      wr_data = sum_mod;
    end else if (s_r == '0) begin
      wr_data = COUNT_W'(1);
    end else begin
      wr_data = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.upd || cmd_i.fetch) begin
      rd_hi_r <= mem[s_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.upd) begin
      rd_lo_r <= mem[addr_lo];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pend_r <= 1'b0;
    end else begin
      wr_pend_r <= cmd_i.upd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.upd) begin
      wr_addr_r <= s_r;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.out_load) begin
      out_count_r <= rd_hi_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_subset_count = out_count_r;

  always_comb begin
    sts_o.item_fits = (32'(in_element_value) <= 32'(eff_target));
    sts_o.item_last = in_last_element;
    sts_o.at_low    = (s_r == v_r);
    sts_o.last      = last_r;
    sts_o.clr_done  = (32'(s_r) == MAX_SUM);
    sts_o.out_free  = !out_valid_r || out_ready;
  end

  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_pend_r && cmd_i.clr_wr))
    else $error("update write-back collides with clearing write");

  a_update_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.upd |-> (s_r >= v_r) && (s_r <= t_r))
    else $error("update address outside the element window");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.out_load |-> (!out_valid_r || out_ready))
    else $error("result overwrites an unread result");

  a_count_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_count_r < COUNT_MOD))
    else $error("result count not reduced by the modulus");

endmodule

`default_nettype wire

/* hw/rtl/ssc_ctrl.sv */
// Controller of the subset sum counter: the state machine that sequences the
// clearing sweep, the per-element update walk, the result fetch and delivery.
// Depends on ssc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire ssc_pkg::ssc_status_t sts_i,
  output ssc_pkg::ssc_cmd_t         cmd_o
);
  import ssc_pkg::*;

  ssc_state_t state_r;
  ssc_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.load_item = 1'b1;
          if (sts_i.item_fits) begin
            state_nxt = ST_UPDATE;
          end else if (sts_i.item_last) begin
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_UPDATE: begin
        cmd_o.upd = 1'b1;
        if (sts_i.at_low) begin
          state_nxt = ST_DRAIN;
        end else begin
          cmd_o.dec = 1'b1;
        end
      end
      ST_DRAIN: begin
        // The last write-back of the walk lands in this cycle.
        if (sts_i.last) begin
          cmd_o.seek_tgt = 1'b1;
          state_nxt      = ST_FETCH;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_nxt   = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.clr_rst  = 1'b1;
          state_nxt      = ST_CLEAR;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        cmd_o.clr_rst = 1'b1;
      end
    endcase
  end

  a_one_address_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd_o.load_item, cmd_o.seek_tgt, cmd_o.clr_rst, cmd_o.dec, cmd_o.clr_wr}))
    else $error("conflicting address counter commands");

  a_walk_ends_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE && sts_i.at_low) |=> (state_r == ST_DRAIN))
    else $error("update walk did not end in the drain state");

  a_result_then_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.out_load |=> (state_r == ST_CLEAR))
    else $error("table not cleared after a result");

endmodule

`default_nettype wire

/* hw/rtl/subset_sum_counter_top.sv */
// Top level of the subset sum counter: the controller and the datapath.
// Depends on ssc_pkg, ssc_ctrl and ssc_datapath.
//
// Usage: the set's elements arrive one per item on the in_ channel (valid and
// ready); in_last_element marks the item that closes the set. That item gives
// one item on the out_ channel: the number of subsets whose sum equals the
// target, modulo 1000000007. Other items give no result.
// The target is written through cfg_wr_en / cfg_wr_data while the block is idle.
// Timing: an element v not above the target t keeps in_ready low from
// acceptance until its table walk ends; the walk reads and writes one entry
// per cycle through the table memory. An element above the target that is
// not last leaves in_ready high. A last element has its count fetched, then
// the table is swept back to its cleared state, one entry per cycle, before
// the next item is accepted. After reset the same sweep runs before in_ready
// first rises; configuration writes are taken during it.
// The result sits in an output register, so a stalled receiver does not hold
// up the sweep or the next set's updates; only the next result waits for it.
`timescale 1ns / 1ps
`default_nettype none

module subset_sum_counter_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic [ssc_pkg::TARGET_W-1:0] cfg_wr_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [ssc_pkg::VALUE_W-1:0]  in_element_value,
  input  wire logic                         in_last_element,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [ssc_pkg::COUNT_W-1:0]       out_subset_count
);
  import ssc_pkg::*;

  ssc_cmd_t    cmd;
  ssc_status_t sts;

  // The controller sequences; the datapath owns the table and the counters.
  ssc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  ssc_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_element_value (in_element_value),
    .in_last_element  (in_last_element),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_subset_count (out_subset_count),
    .cmd_i            (cmd),
    .sts_o            (sts)
  );

endmodule

`default_nettype wire

/* tb/sv/subset_sum_counter_top_tb.sv */
// Self-checking testbench for subset_sum_counter_top: a scoreboard class that
// keeps its own table of ways per partial sum, plus tasks that drive the ports.
// Depends on ssc_pkg and the subset_sum_counter_top RTL.
`timescale 1ns / 1ps

module subset_sum_counter_top_tb;

  import ssc_pkg::*;

  // Cycles of quiet time after the last expected result. This covers the
  // longest table walk (target 1023, element 0) or the clearing sweep.
  localparam int SETTLE_CYCLES = 1100;
  localparam int ITEMS_PER_SEGMENT = 72;

  // The scoreboard predicts the count for every set. It tracks the table of
  // ways per partial sum item by item, exactly as the block should.
  class subset_count_board;
    logic [COUNT_W-1:0]  ways_per_sum [TBL_DEPTH];
    logic [TARGET_W-1:0] target;
    logic [COUNT_W-1:0]  expected_counts [$];
    int                  mismatches;

    function new();
      target = '0;
      mismatches = 0;
      clear_ways();
    endfunction

    function void clear_ways();
      foreach (ways_per_sum[i]) ways_per_sum[i] = '0;
      ways_per_sum[0] = COUNT_W'(1);
    endfunction

    function void set_target(logic [TARGET_W-1:0] t);
      target = t;
    endfunction

    function logic [COUNT_W-1:0] add_mod(logic [COUNT_W-1:0] a, logic [COUNT_W-1:0] b);
      logic [COUNT_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= {1'b0, COUNT_MOD}) sum = sum - {1'b0, COUNT_MOD};
      return sum[COUNT_W-1:0];
    endfunction

    // Applies one accepted element to the table. A last element closes the
    // set: its count at the target is queued and the table starts over.
    function void note_input(logic [VALUE_W-1:0] value, logic last);
      int t;
      int v;
      t = (int'(target) > MAX_SUM) ? MAX_SUM : int'(target);
      v = int'(value);
      if (v <= t) begin
        // Walking downward means ways_per_sum[s - v] still holds the count
        // from before this element, so each element is used at most once.
        for (int s = t; s >= v; s--) begin
          ways_per_sum[s] = add_mod(ways_per_sum[s], ways_per_sum[s - v]);
        end
      end
      if (last) begin
        expected_counts.push_back(ways_per_sum[t]);
        clear_ways();
      end
    endfunction

    function void check_result(logic [COUNT_W-1:0] got);
      logic [COUNT_W-1:0] want;
      if (expected_counts.size() == 0) begin
        $error("subset_count: unexpected result, actual %0d", got);
        mismatches++;
      end else begin
        want = expected_counts.pop_front();
        if (got !== want) begin
          $error("subset_count mismatch: expected %0d, actual %0d", want, got);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return expected_counts.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [TARGET_W-1:0] cfg_wr_data;
  logic                in_valid;
  logic                in_ready;
  logic [VALUE_W-1:0]  in_element_value;
  logic                in_last_element;
  logic                out_valid;
  logic                out_ready;
  logic [COUNT_W-1:0]  out_subset_count;

  subset_count_board board;

  // Idle rates in percent. The sender waits before an item with this chance
  // per cycle; the receiver holds out_ready low with its own chance per cycle.
  int sender_idle_pct;
  int receiver_stall_pct;

  subset_sum_counter_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_element_value (in_element_value),
    .in_last_element  (in_last_element),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_subset_count (out_subset_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety net: a hung handshake ends the run here; the limit is several times
  // the length of the real run.
  initial begin
    #60_000_000;
    $display("Verification failed");
    $finish;
  end

  // Result side. Values are read right after the edge, before any register
  // in the block updates, so they are the values that the edge sampled.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_result(out_subset_count);
    end
    out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // Presents one item and holds it until the block takes it. Idle cycles are
  // inserted first so that gaps land on every phase of the table walk.
  task automatic send_item(logic [VALUE_W-1:0] value, logic last);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_element_value <= value;
    in_last_element  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_input(value, last);
  endtask

  // The target register only changes while the block is idle.
  task automatic write_target(logic [TARGET_W-1:0] t);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= t;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    board.set_target(t);
  endtask

  // Waits until every expected count has arrived, then lets a walk or a
  // clearing sweep that may still be running finish.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Draws one element for target t: zeros, values that fit, values at or just
  // below the target, values just above it, and arbitrary 16-bit values.
  function automatic logic [VALUE_W-1:0] pick_element(int t);
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return '0;
    if (r < 62) return VALUE_W'($urandom_range(0, t));
    if (r < 77) return VALUE_W'(t - $urandom_range(0, (t < 3) ? t : 3));
    if (r < 90) return VALUE_W'($urandom_range(t + 1, t + 40));
    return VALUE_W'($urandom_range(0, 65535));
  endfunction

  // Sends whole sets until the segment has its share of items. Most sets
  // are short; some are long enough for the counts to wrap the modulus.
  task automatic run_segment(int target, int item_budget);
    int sent;
    int set_len;
    sent = 0;
    while (sent < item_budget) begin
      if ($urandom_range(0, 99) < 80) set_len = $urandom_range(1, 10);
      else set_len = $urandom_range(20, 40);
      for (int i = 0; i < set_len; i++) begin
        send_item(pick_element(target), i == set_len - 1);
      end
      sent += set_len;
    end
  endtask

  initial begin
    int seg_target;

    board = new;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    rst_n            <= 1'b0;
    cfg_wr_en        <= 1'b0;
    cfg_wr_data      <= '0;
    in_valid         <= 1'b0;
    in_element_value <= '0;
    in_last_element  <= 1'b0;
    out_ready        <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. The target is still at its reset value of zero: a
    // single zero element doubles the empty subset to two, and an element
    // above the target leaves only the empty subset.
    send_item(16'd0, 1'b1);
    send_item(16'd5, 1'b1);

    // Largest target: the full 16-bit value is above it, an element equal
    // to the target, a zero, and values that walk the whole table.
    wait_quiet();
    write_target(10'd1023);
    send_item(16'hFFFF, 1'b0);
    send_item(16'd1023, 1'b0);
    send_item(16'd0, 1'b0);
    send_item(16'd1, 1'b0);
    send_item(16'd1022, 1'b0);
    send_item(16'd512, 1'b0);
    send_item(16'd511, 1'b0);
    send_item(16'd0, 1'b1);

    // Target changed in the middle of a set: entries above the new target
    // keep what the earlier elements left there, and the result reads the
    // entry at the new target.
    wait_quiet();
    write_target(10'd10);
    send_item(16'd3, 1'b0);
    send_item(16'd7, 1'b0);
    send_item(16'd5, 1'b0);
    wait_quiet();
    write_target(10'd5);
    send_item(16'd5, 1'b0);
    send_item(16'hAAAA, 1'b1);

    // A fresh table at target zero counts just the empty subset; two zeros count four.
    wait_quiet();
    write_target(10'd0);
    send_item(16'd1, 1'b1);
    send_item(16'd0, 1'b0);
    send_item(16'd0, 1'b1);

    // Random part. Four idling modes, each with a small target and one
    // anywhere in the register's range.
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 68;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 68;
        end
        default: begin
          sender_idle_pct    = 34;
          receiver_stall_pct = 34;
        end
      endcase
      for (int seg = 0; seg < 2; seg++) begin
        if (seg == 0) seg_target = $urandom_range(0, 40);
        else seg_target = $urandom_range(0, 1023);
        wait_quiet();
        write_target(TARGET_W'(seg_target));
        run_segment(seg_target, ITEMS_PER_SEGMENT);
      end
    end

    // Drain: every count must arrive, then a quiet window catches extras.
    wait_quiet();
    if (board.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/ssc_pkg.sv
hw/rtl/ssc_datapath.sv
hw/rtl/ssc_ctrl.sv
hw/rtl/subset_sum_counter_top.sv
tb/sv/subset_sum_counter_top_tb.sv
